@@ src/bilinear_zoom_2x_defines.svh @@
// Assertion macros of the checker file of the 2x bilinear zoom block.
`ifndef BILINEAR_ZOOM_2X_DEFINES_SVH
`define BILINEAR_ZOOM_2X_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define BZ2_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property whose consequent must hold in the cycle after its antecedent.
`define BZ2_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/bz2_pkg.sv @@
// Package with the types, constants and helper functions of the 2x bilinear zoom block.
package bz2_pkg;

	localparam int MAX_COLS  = 1024;
	localparam int MAX_ROWS  = 1024;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int SIZE_W    = 11;
	localparam int COORD_W   = 11;
	localparam int PIX_W     = 8;
	localparam int CFG_IDX_W = 4;
	localparam int NRES      = 4;
	localparam int SLOT_W    = $clog2(NRES);

	typedef logic [PIX_W-1:0]     pix_t;
	typedef logic [SIZE_W-1:0]    size_t;
	typedef logic [COORD_W-1:0]   coord_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [SLOT_W-1:0]    slot_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [ROW_W-1:0]     row_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_IMAGE_ROWS = cfg_idx_t'(0);
	localparam cfg_idx_t REG_IMAGE_COLS = cfg_idx_t'(1);

	localparam size_t MAX_COLS_SZ = size_t'(MAX_COLS);
	localparam size_t MAX_ROWS_SZ = size_t'(MAX_ROWS);

	// Result slots of one source pixel, in emission order.
	localparam slot_t SLOT_UL  = slot_t'(0); // (2r-1, 2c-1)
	localparam slot_t SLOT_UP  = slot_t'(1); // (2r-1, 2c)
	localparam slot_t SLOT_LF  = slot_t'(2); // (2r,   2c-1)
	localparam slot_t SLOT_CUR = slot_t'(3); // (2r,   2c)

	// Everything the result sequencer needs to emit the results of one item.
	typedef struct packed {
		logic [NRES-1:0]  mask;
		row_t             r;
		col_t             c;
		logic             img_end;
		pix_t [NRES-1:0]  px;
	} em_load_t;

	function automatic size_t eff_size(size_t v, size_t maxv);
		size_t res;
		if (v == '0) begin
			res = size_t'(1);
		end else if (v > maxv) begin
			res = maxv;
		end else begin
			res = v;
		end
		return res;
	endfunction

	function automatic pix_t avg2(pix_t a, pix_t b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
		return s[PIX_W:1];
	endfunction

endpackage

@@ src/bz2_if.sv @@
// Stream and configuration interfaces of the 2x bilinear zoom block.
interface bz2_pix_if import bz2_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink (input valid, input pixel_in, output ready);
endinterface

interface bz2_res_if import bz2_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t out_row;
	coord_t out_col;
	pix_t   pixel_out;
	logic   last_of_run;
	logic   end_of_image;

	modport source (output valid, output out_row, output out_col, output pixel_out,
		output last_of_run, output end_of_image, input ready);
	modport sink (input valid, input out_row, input out_col, input pixel_out,
		input last_of_run, input end_of_image, output ready);
endinterface

interface bz2_cfg_if import bz2_pkg::*; ();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	size_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/bz2_line_buf.sv @@
// Line buffer holding the previous source row, one read and one write port.
module bz2_line_buf import bz2_pkg::*; (
	input  logic clk,
	input  logic rd_en,
	input  col_t rd_addr,
	output pix_t rd_data,
	input  logic wr_en,
	input  col_t wr_addr,
	input  pix_t wr_data
);

	pix_t mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ src/bz2_emitter.sv @@
// Result sequencer: holds the results of one item and hands them out one per cycle while the result channel is ready.
module bz2_emitter import bz2_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  em_load_t ld,
	output logic     free,
	bz2_res_if.source res
);

	logic [NRES-1:0] mask_q;
	row_t            r_q;
	col_t            c_q;
	logic            img_end_q;
	pix_t [NRES-1:0] px_q;

	slot_t           sel;
	logic [NRES-1:0] rest;
	logic            last;
	logic            take;
	coord_t          row_base;
	coord_t          col_base;

	always_comb begin
		sel = SLOT_CUR;
		for (int i = NRES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				sel = slot_t'(i);
			end
		end
		rest = mask_q;
		rest[sel] = 1'b0;
		last = (rest == '0);
	end

	assign row_base = coord_t'({r_q, 1'b0});
	assign col_base = coord_t'({c_q, 1'b0});

	assign res.valid        = |mask_q;
	assign res.pixel_out    = px_q[sel];
	assign res.last_of_run  = last;
	assign res.end_of_image = last && img_end_q;
	assign res.out_row      = (sel == SLOT_UL || sel == SLOT_UP) ?
		row_base - coord_t'(1) : row_base;
	assign res.out_col      = (sel == SLOT_UL || sel == SLOT_LF) ?
		col_base - coord_t'(1) : col_base;

	assign take = res.valid && res.ready;
	assign free = (mask_q == '0) || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= ld.mask;
		end else if (take) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			r_q       <= ld.r;
			c_q       <= ld.c;
			img_end_q <= ld.img_end;
			px_q      <= ld.px;
		end
	end

endmodule

@@ src/bilinear_zoom_2x.sv @@
// Top level of the streaming 2x bilinear zoom for 8-bit grey images.
//
//  Channel | Direction | Carries                                        | Accepted when
//  pix     | in        | pixel_in                                       | valid && ready
//  res     | out       | out_row, out_col, pixel_out, last_of_run,      | valid && ready
//          |           | end_of_image                                   |
//  cfg     | in        | index, data (image_rows = 0, image_cols = 1)   | valid && ready
//
// Each source item gives one to four results, one per cycle while the result channel is
// ready; an item off the first row and first column gives all four.
// An accepted item waits in the input stage while the line buffer is read, and then
// all its results are computed into the sequencer, which hands them out.
// Reset sets both sizes to one and clears the position counters and the neighbour
// pixels; the line buffer is not cleared, since every entry is written before it is read.
// A stall on the result channel holds the sequencer, then the input stage, then pix.ready.
module bilinear_zoom_2x import bz2_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	bz2_pix_if.sink   pix,
	bz2_res_if.source res,
	bz2_cfg_if.sink   cfg
);

	// Configuration registers, to be written by the user only while the block is idle; the block does not enforce it.
	size_t rows_q;
	size_t cols_q;
	size_t eff_rows;
	size_t eff_cols;

	// Source position of the next item to be accepted.
	col_t col_q;
	row_t row_q;

	// Input stage: the accepted item waits here while the line buffer read completes
	// and until the sequencer can take its results.
	logic valid_s1;
	pix_t px_s1;
	col_t c_s1;
	row_t r_s1;
	logic img_end_s1;
	logic fwd_s1;
	pix_t fwd_px_s1;

	// Left and upper-left neighbours of the item in the input stage.
	pix_t left_q;
	pix_t upleft_q;

	logic     in_acc;
	logic     row_end;
	logic     img_end;
	logic     em_free;
	logic     s1_move;
	pix_t     rd_data;
	pix_t     up;
	pix_t     h_cur;
	pix_t     h_prev;
	em_load_t ld;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= size_t'(1);
			cols_q <= size_t'(1);
		end else if (cfg.valid) begin
			if (cfg.index == REG_IMAGE_ROWS) begin
				rows_q <= cfg.data;
			end else if (cfg.index == REG_IMAGE_COLS) begin
				cols_q <= cfg.data;
			end
		end
	end

	// A size of zero counts as one, a size above the maximum as the maximum.
	assign eff_rows = eff_size(rows_q, MAX_ROWS_SZ);
	assign eff_cols = eff_size(cols_q, MAX_COLS_SZ);

	// The item moves on when the sequencer hands out its last pending result, so a new
	// item can be accepted in the same cycle.
	assign s1_move   = valid_s1 && em_free;
	assign pix.ready = !valid_s1 || s1_move;
	assign in_acc    = pix.valid && pix.ready;

	// A count at or beyond the size wraps after this item, so that a size change in the
	// middle of an image still brings the counters back into range.
	assign row_end = (size_t'(col_q) + size_t'(1)) >= eff_cols;
	assign img_end = row_end && ((size_t'(row_q) + size_t'(1)) >= eff_rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= img_end ? '0 : row_q + row_t'(1);
			end else begin
				col_q <= col_q + col_t'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// The outgoing item writes its column in the same cycle as the new item reads; when
	// both address the same column (a one-column image) the written pixel is forwarded.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1      <= pix.pixel_in;
			c_s1       <= col_q;
			r_s1       <= row_q;
			img_end_s1 <= img_end;
			fwd_s1     <= s1_move && (c_s1 == col_q);
			fwd_px_s1  <= px_s1;
		end
	end

	bz2_line_buf u_line_buf (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_move),
		.wr_addr (c_s1),
		.wr_data (px_s1)
	);

	assign up = fwd_s1 ? fwd_px_s1 : rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			upleft_q <= '0;
		end else if (s1_move) begin
			left_q   <= px_s1;
			upleft_q <= up;
		end
	end

	// Horizontal means of the current and previous rows; the result at odd row and odd column
	// takes the mean of the two already rounded horizontal values.
	assign h_cur  = avg2(left_q, px_s1);
	assign h_prev = avg2(upleft_q, up);

	always_comb begin
		ld.r             = r_s1;
		ld.c             = c_s1;
		ld.img_end       = img_end_s1;
		ld.mask          = '0;
		ld.mask[SLOT_UL] = (r_s1 != '0) && (c_s1 != '0);
		ld.mask[SLOT_UP] = (r_s1 != '0);
		ld.mask[SLOT_LF] = (c_s1 != '0);
		ld.mask[SLOT_CUR] = 1'b1;
		ld.px            = '0;
		ld.px[SLOT_UL]   = avg2(h_prev, h_cur);
		ld.px[SLOT_UP]   = avg2(up, px_s1);
		ld.px[SLOT_LF]   = h_cur;
		ld.px[SLOT_CUR]  = px_s1;
	end

	bz2_emitter u_emitter (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (s1_move),
		.ld     (ld),
		.free   (em_free),
		.res    (res)
	);

endmodule

@@ src/bz2_checker.sv @@
// Port-level checker of the 2x bilinear zoom block and its binding to the top level.
`include "bilinear_zoom_2x_defines.svh"

module bz2_checker import bz2_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_ready,
	input coord_t out_row,
	input coord_t out_col,
	input pix_t   pixel_out,
	input logic   last_of_run,
	input logic   end_of_image
);

	logic [2*COORD_W+PIX_W+1:0] payload;

	assign payload = {out_row, out_col, pixel_out, last_of_run, end_of_image};

	`BZ2_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
	`BZ2_ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(payload), "stalled result changed")
	`BZ2_ASSERT(a_end_is_last, out_valid && end_of_image |-> last_of_run, "end of image on a result that is not last")
	`BZ2_ASSERT(a_last_is_copy, out_valid && last_of_run |-> !out_row[0] && !out_col[0], "last result of an item is not the copied pixel")

endmodule

bind bilinear_zoom_2x bz2_checker u_bz2_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (res.valid),
	.out_ready    (res.ready),
	.out_row      (res.out_row),
	.out_col      (res.out_col),
	.pixel_out    (res.pixel_out),
	.last_of_run  (res.last_of_run),
	.end_of_image (res.end_of_image)
);

@@ verif/bilinear_zoom_2x_tb.sv @@
// Self-checking testbench for the 2x bilinear zoom: directed images, size limits and random images.
module bilinear_zoom_2x_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bz2_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 10;
	// Time to go quiet after the last expected result: an item passes the input stage, then the
	// sequencer, which holds up to four of its results.
	localparam int DRAIN_CYCLES   = 8;
	localparam int HOLD_CYCLES    = 300;
	// The longest quiet stretch in a correct run is the long hold-off plus a sender gap.
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_ITEMS   = 110;
	// Items sent into each image whose size register sits at a limit.
	localparam int LIMIT_ITEMS    = 8;
	// An index that names no register; the block must ignore writes to it.
	localparam cfg_idx_t REG_UNUSED = cfg_idx_t'(15);

	// Pixel patterns for the random images.
	localparam int PAT_EXTREMES = 0;
	localparam int PAT_NARROW   = 1;

	typedef struct packed {
		coord_t row;
		coord_t col;
		pix_t   px;
		logic   last_of_run;
		logic   end_of_image;
	} zoom_px_t;

	logic clk;
	logic arst_n;

	bz2_pix_if pix_ch ();
	bz2_res_if res_ch ();
	bz2_cfg_if cfg_ch ();

	bilinear_zoom_2x dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Our own copy of the block's state: the previous source row, the two neighbour pixels,
	// the source position of the next item and the two size registers.
	pix_t     line_buf [MAX_COLS];
	bit       line_written [MAX_COLS];
	pix_t     left_px;
	pix_t     upper_left_px;
	int       col_pos;
	int       row_pos;
	size_t    rows_reg;
	size_t    cols_reg;

	// Zoomed pixels predicted but not yet seen on the result channel, oldest first.
	zoom_px_t zoom_expected [$];

	int fail_count;
	int items_sent;
	int results_checked;
	int images_seen;
	int reg_writes;
	int long_holds;
	int quiet_cycles;

	// Knobs that the test tasks turn, and the sender's burst count; the sender and the receiver read them.
	bit   input_gaps;
	bit   output_stalls;
	logic hold_req;
	int   burst_left;

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// A size register of zero means one; anything above the maximum means the maximum.
	function automatic int clamp_size(size_t v, int lim);
		if (v == '0)
			return 1;
		if (int'(v) > lim)
			return lim;
		return int'(v);
	endfunction

	function automatic pix_t round_mean(pix_t a, pix_t b);
		int unsigned s;
		s = a + b + 1;
		return pix_t'(s >> 1);
	endfunction

	// Works out the one to four zoomed pixels that a source pixel releases, in the order the
	// block sends them: upper-left, upper, left, then the copy of the pixel itself.
	function automatic void predict_zoom(pix_t a);
		int       rows;
		int       cols;
		int       r;
		int       c;
		int       n;
		pix_t     up;
		pix_t     h_cur;
		zoom_px_t run [4];
		rows = clamp_size(rows_reg, MAX_ROWS);
		cols = clamp_size(cols_reg, MAX_COLS);
		r = row_pos;
		c = col_pos;
		n = 0;
		up = line_buf[c];
		// The stimulus is built so that this never happens; if it does, the test is at fault.
		if (r >= 1 && !line_written[c]) begin
			$error("stimulus reads line buffer entry %0d before it was written", c);
			fail_count++;
		end
		h_cur = round_mean(left_px, a);
		if (r >= 1) begin
			if (c >= 1) begin
				run[n] = '{coord_t'(2 * r - 1), coord_t'(2 * c - 1),
					round_mean(round_mean(upper_left_px, up), h_cur), 1'b0, 1'b0};
				n++;
			end
			run[n] = '{coord_t'(2 * r - 1), coord_t'(2 * c), round_mean(up, a), 1'b0, 1'b0};
			n++;
		end
		if (c >= 1) begin
			run[n] = '{coord_t'(2 * r), coord_t'(2 * c - 1), h_cur, 1'b0, 1'b0};
			n++;
		end
		run[n] = '{coord_t'(2 * r), coord_t'(2 * c), a, 1'b0, 1'b0};
		n++;
		run[n - 1].last_of_run = 1'b1;
		run[n - 1].end_of_image = logic'((c + 1 >= cols) && (r + 1 >= rows));
		for (int i = 0; i < n; i++)
			zoom_expected.push_back(run[i]);

		line_buf[c] = a;
		line_written[c] = 1'b1;
		upper_left_px = up;
		left_px = a;
		if (c + 1 >= cols) begin
			col_pos = 0;
			row_pos = (r + 1 >= rows) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endfunction

	function automatic pix_t pick_pixel(int pattern);
		int unsigned pick;
		pick = $urandom_range(0, 3);
		case (pattern)
			PAT_EXTREMES: return pick[1] ? (pick[0] ? 8'd255 : 8'd254) : (pick[0] ? 8'd1 : 8'd0);
			PAT_NARROW: return pix_t'($urandom_range(100, 103));
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Everything is sampled at the rising edge, before the nonblocking updates of that edge
	// land, so register writes, results and items are seen exactly as the block saw them.
	// An item's results come out only after it has passed the input stage into the sequencer, so
	// checking before predicting within one edge can never pop an entry that is only now being pushed.
	always @(posedge clk) begin : monitor
		zoom_px_t want;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready) begin
				case (cfg_ch.index)
					REG_IMAGE_ROWS: rows_reg = cfg_ch.data;
					REG_IMAGE_COLS: cols_reg = cfg_ch.data;
					default: ;
				endcase
				reg_writes++;
			end
			if (res_ch.valid && res_ch.ready) begin
				results_checked++;
				if (res_ch.end_of_image)
					images_seen++;
				if (zoom_expected.size() == 0) begin
					$error("result at row %0d col %0d arrived with nothing expected",
						res_ch.out_row, res_ch.out_col);
					fail_count++;
				end else begin
					want = zoom_expected.pop_front();
					if (res_ch.out_row !== want.row) begin
						$error("out_row: expected %0d, got %0d", want.row, res_ch.out_row);
						fail_count++;
					end
					if (res_ch.out_col !== want.col) begin
						$error("out_col: expected %0d, got %0d", want.col, res_ch.out_col);
						fail_count++;
					end
					if (res_ch.pixel_out !== want.px) begin
						$error("pixel_out: expected %0d, got %0d", want.px, res_ch.pixel_out);
						fail_count++;
					end
					if (res_ch.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0d, got %0d",
							want.last_of_run, res_ch.last_of_run);
						fail_count++;
					end
					if (res_ch.end_of_image !== want.end_of_image) begin
						$error("end_of_image: expected %0d, got %0d",
							want.end_of_image, res_ch.end_of_image);
						fail_count++;
					end
				end
			end
			if (pix_ch.valid && pix_ch.ready) begin
				predict_zoom(pix_ch.pixel_in);
				items_sent++;
			end
		end
	end

	// The receiver alternates runs of ready and stalled cycles when stalls are enabled, and
	// on request holds ready low for a long stretch that it counts itself.
	always @(posedge clk) begin : receiver
		int hold_left;
		int run_left;
		bit rdy_now;
		if (hold_req) begin
			hold_req <= 1'b0;
			hold_left = HOLD_CYCLES;
			long_holds++;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			if (run_left <= 0) begin
				if (output_stalls && rdy_now) begin
					rdy_now = 1'b0;
					run_left = $urandom_range(1, 6);
				end else begin
					rdy_now = 1'b1;
					run_left = $urandom_range(1, 16);
				end
			end
			run_left--;
			res_ch.ready <= rdy_now;
		end
	end

	// Ends the run if no item, result or register write is accepted for too long.
	always @(posedge clk) begin
		if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no handshake for %0d cycles, %0d zoomed pixels still awaited",
				WATCHDOG_LIMIT, zoom_expected.size());
			$display("** bilinear_zoom_2x: FAILED **");
			$finish;
		end
	end

	// Offers one source pixel and returns at the edge where it is taken. The sender works in
	// bursts; valid only drops at the start of a gap, never between two items of one burst.
	task automatic send_pixel(pix_t v);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = input_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				pix_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		pix_ch.valid <= 1'b1;
		pix_ch.pixel_in <= v;
		do @(posedge clk); while (!pix_ch.ready);
	endtask

	// Stops offering items and waits until every predicted pixel has come out and the block
	// has had time to go idle, so that a register write lands between items. The first edge
	// lets the monitor record the item taken at the edge this task was called on.
	task automatic settle();
		pix_ch.valid <= 1'b0;
		@(posedge clk);
		while (zoom_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so that back-to-back writes need no second assignment in one step;
	// the caller lowers it after its last write.
	task automatic write_reg(cfg_idx_t idx, size_t val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_size(size_t rows, size_t cols);
		write_reg(REG_IMAGE_ROWS, rows);
		write_reg(REG_IMAGE_COLS, cols);
		cfg_ch.valid <= 1'b0;
	endtask

	// After reset both sizes are one, so each item is a whole 1 x 1 image of its own.
	task automatic test_reset_sizes();
		input_gaps = 1'b0;
		output_stalls = 1'b0;
		send_pixel(8'h00);
		send_pixel(8'hFF);
		settle();
	endtask

	// A 3 x 3 image whose neighbours give odd sums, so every rounding path is exercised, and
	// whose pixels between them set and clear every bit.
	task automatic test_rounding_3x3();
		pix_t img [9];
		img = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127, 8'd255, 8'd0, 8'd3};
		set_size(size_t'(3), size_t'(4'd3));
		foreach (img[i])
			send_pixel(img[i]);
		settle();
	endtask

	// Sizes changed part way through an image. The column count shrinks to no more than the
	// current column, so the row wraps after the next item; then the row count shrinks to no
	// more than the current row, so the image ends with that row. Only entries written by the
	// row above are read, since the rows keep to columns the first row filled.
	task automatic test_resize_mid_image();
		set_size(size_t'(3), size_t'(4));
		repeat (6) send_pixel(pick_pixel(-1));
		settle();
		write_reg(REG_IMAGE_COLS, size_t'(2));
		cfg_ch.valid <= 1'b0;
		send_pixel(pick_pixel(-1));
		settle();
		write_reg(REG_IMAGE_ROWS, size_t'(2));
		cfg_ch.valid <= 1'b0;
		repeat (2) send_pixel(pick_pixel(-1));
		settle();
	endtask

	// Size registers at their limits: a zero row count with an all-ones column count, then
	// the reverse. Each image is cut short by shrinking the running size to one, so the
	// image ends with the next item.
	task automatic test_size_limits();
		input_gaps = 1'b1;
		output_stalls = 1'b1;
		write_reg(REG_UNUSED, '1);
		set_size('0, '1);
		repeat (LIMIT_ITEMS) send_pixel(pick_pixel(-1));
		settle();
		write_reg(REG_IMAGE_COLS, size_t'(1));
		cfg_ch.valid <= 1'b0;
		send_pixel(pick_pixel(-1));
		settle();
		set_size('1, '0);
		repeat (LIMIT_ITEMS) send_pixel(pick_pixel(-1));
		settle();
		write_reg(REG_IMAGE_ROWS, size_t'(1));
		cfg_ch.valid <= 1'b0;
		send_pixel(pick_pixel(-1));
		settle();
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering items, so the
	// block fills and must stall its input without losing or reordering anything.
	task automatic test_backpressure();
		input_gaps = 1'b0;
		output_stalls = 1'b0;
		set_size(size_t'(3), size_t'(5));
		hold_req <= 1'b1;
		repeat (15) send_pixel(pick_pixel(-1));
		settle();
	endtask

	// Whole images of random size and content, mostly small, some wide, with the sender and
	// the receiver idling at random from one phase to the next.
	task automatic test_random_images();
		int count;
		int cur_rows;
		int cur_cols;
		int new_rows;
		int new_cols;
		int images;
		int pattern;
		int unsigned mask;
		count = 0;
		mask = 3;
		while (count < RANDOM_ITEMS) begin
			input_gaps = $urandom_range(0, 2) != 0;
			output_stalls = $urandom_range(0, 2) != 0;
			if ($urandom_range(0, 4) == 0) begin
				new_rows = $urandom_range(1, 3);
				new_cols = $urandom_range(9, 48);
			end else begin
				new_rows = $urandom_range(1, 5);
				new_cols = $urandom_range(1, 8);
			end
			// A size of one is sometimes written as zero, which the block reads as one.
			if (mask[0]) begin
				cur_rows = new_rows;
				write_reg(REG_IMAGE_ROWS, (new_rows == 1 && $urandom_range(0, 1) == 0) ?
					size_t'(0) : size_t'(new_rows));
			end
			if (mask[1]) begin
				cur_cols = new_cols;
				write_reg(REG_IMAGE_COLS, (new_cols == 1 && $urandom_range(0, 1) == 0) ?
					size_t'(0) : size_t'(new_cols));
			end
			cfg_ch.valid <= 1'b0;
			images = (cur_rows * cur_cols > 40) ? 1 : $urandom_range(1, 3);
			pattern = $urandom_range(0, 3);
			repeat (images * cur_rows * cur_cols) begin
				send_pixel(pick_pixel(pattern));
				count++;
			end
			settle();
			mask = $urandom_range(1, 3);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_in = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		hold_req = 1'b0;
		input_gaps = 1'b0;
		output_stalls = 1'b0;
		burst_left = 0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		images_seen = 0;
		reg_writes = 0;
		long_holds = 0;
		quiet_cycles = 0;
		// State after reset: both sizes one, counters and neighbours cleared.
		rows_reg = size_t'(1);
		cols_reg = size_t'(1);
		left_px = '0;
		upper_left_px = '0;
		col_pos = 0;
		row_pos = 0;
		foreach (line_written[i])
			line_written[i] = 1'b0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_sizes();
		test_rounding_3x3();
		test_resize_mid_image();
		test_size_limits();
		test_backpressure();
		test_random_images();
		settle();

		$display("Covered %0d source items and %0d zoomed pixels in %0d complete images.",
			items_sent, results_checked, images_seen);
		$display("Used %0d register writes, sizes from zero to all ones, %0d long hold-off(s).",
			reg_writes, long_holds);
		if (fail_count == 0)
			$display("** bilinear_zoom_2x: PASSED **");
		else
			$display("** bilinear_zoom_2x: FAILED **");
		$finish;
	end

endmodule
